>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. The SYNTH build sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/msr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_pkg
// Types and fixed constants shared by the splat radius estimator.
// ----------------------------------------------------------------------------
package msr_pkg;

   localparam int IDX_FIELD_W = 10;
   localparam int POS_FIELD_W = 16;
   localparam int RADIUS_W    = 17;
   localparam int MODE_W      = 2;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FACE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]             mode;
      logic [IDX_FIELD_W-1:0]        vertex_index;
      logic signed [POS_FIELD_W-1:0] pos_x;
      logic signed [POS_FIELD_W-1:0] pos_y;
      logic signed [POS_FIELD_W-1:0] pos_z;
      logic [IDX_FIELD_W-1:0]        corner_a;
      logic [IDX_FIELD_W-1:0]        corner_b;
      logic [IDX_FIELD_W-1:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] query_index;
      logic [RADIUS_W-1:0]    radius;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } lane_ctl_type;

   typedef struct packed {
      logic clr;
      logic rd_en;
      logic upd;
   } merge_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_sts_type;

endpackage

>>> src/mesh_splat_radius.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_splat_radius
// Per-vertex splat radius estimator for a triangle mesh.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. A load beat stores a vertex position
// and clears its running maximum; a face beat folds |3p-S|^2 of each of its
// three corners into that corner's maximum; a query beat returns
// floor(2*isqrt(max)/5), the radius as an unsigned integer (Q17.0). Every
// index is first reduced modulo MAX_VERTICES, in ST_WRAP1 (quotient) and
// ST_WRAP2 (remainder). In a face, three corner lanes each read their own
// copy of the position store and compute the scaled distances side by
// side, and then the single-ported maximum store is updated corner after
// corner, a read and a write for each. A query runs through the square
// root unit, which yields one result bit per cycle. Results leave through
// an output register, so the next beat is taken while a radius still
// waits on a stalled result channel. Reading a vertex that was never
// loaded returns an undefined radius.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_splat_radius #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msr_pkg::rsp_type  rsp_data
);

   localparam int IW   = $clog2(MAX_VERTICES);
   localparam int FW   = msr_pkg::IDX_FIELD_W;
   localparam int SUMW = COORD_BITS + 2;
   localparam int SW   = 2 * COORD_BITS + 4;
   localparam int RW   = COORD_BITS + 2;
   localparam int XW   = RW + 1;
   localparam int K5   = XW + 3;
   localparam longint unsigned RECIP5 = ((64'd1 << K5) / 5) + 1;
   localparam int WK   = FW + 1 + IW;
   localparam longint unsigned RECIPW =
      ((64'd1 << WK) + MAX_VERTICES - 1) / MAX_VERTICES;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRAP1, ST_WRAP2, ST_DISPATCH, ST_F1, ST_F2,
      ST_MRD, ST_MWR, ST_QRD, ST_QSQ, ST_QOUT
   } state_type;

   state_type                   state_ff;
   logic [msr_pkg::MODE_W-1:0]  mode_ff;
   logic [FW-1:0]               raw_ff  [4];
   logic [FW-1:0]               q_ff    [4];
   logic [FW-1:0]               q_in    [4];
   logic [IW-1:0]               idx_ff  [4];
   logic [IW-1:0]               idx_in  [4];
   logic [FW-1:0]               rem_w   [4];
   logic [2:0][COORD_BITS-1:0]  coord_ff;
   logic [1:0]                  k_ff;
   logic [XW+K5-1:0]            prod_ff;
   logic [XW+K5-1:0]            prod_in;
   logic                        rsp_valid_ff;
   msr_pkg::rsp_type            rsp_data_ff;

   msr_pkg::lane_ctl_type       lane_ctl;
   msr_pkg::merge_ctl_type      mrg_ctl;
   msr_pkg::sqrt_sts_type       sq_sts;
   logic [IW-1:0]               mrg_idx;
   logic [2:0][COORD_BITS-1:0]  lane_pos [3];
   logic [SW-1:0]               lane_acc [3];
   logic [2:0][SUMW-1:0]        sum_ax;
   logic [SW-1:0]               max_rd;
   logic [RW-1:0]               root;
   logic                        out_free;

   // Index reduction: quotient by reciprocal, then remainder.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_in[i]   = FW'((64'(raw_ff[i]) * RECIPW) >> WK);
         rem_w[i]  = raw_ff[i] - FW'(32'(q_ff[i]) * MAX_VERTICES);
         idx_in[i] = IW'(rem_w[i]);
      end
   end

   // Face sum per axis from the three lane reads.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_ax[j] = SUMW'($signed(lane_pos[0][j])) + SUMW'($signed(lane_pos[1][j]))
                   + SUMW'($signed(lane_pos[2][j]));
      end
   end

   always_comb begin
      lane_ctl.wr_en = (state_ff == ST_DISPATCH) && (mode_ff == msr_pkg::MODE_LOAD);
      lane_ctl.rd_en = (state_ff == ST_DISPATCH) && (mode_ff == msr_pkg::MODE_FACE);
      mrg_ctl.clr    = lane_ctl.wr_en;
      mrg_ctl.rd_en  = ((state_ff == ST_DISPATCH) && (mode_ff == msr_pkg::MODE_QUERY))
                    || (state_ff == ST_MRD);
      mrg_ctl.upd    = (state_ff == ST_MWR);
      mrg_idx        = (state_ff == ST_DISPATCH) ? idx_ff[0] : idx_ff[k_ff + 2'd1];
      prod_in        = (XW + K5)'({root, 1'b0}) * (XW + K5)'(RECIP5);
      out_free       = !rsp_valid_ff || !rsp_stall;
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      msr_lane #(
         .MAX_VERTICES (MAX_VERTICES),
         .COORD_BITS   (COORD_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .wr_idx (idx_ff[0]),
         .wr_pos (coord_ff),
         .rd_idx (idx_ff[l + 1]),
         .sum_ax (sum_ax),
         .pos    (lane_pos[l]),
         .acc    (lane_acc[l])
      );
   end

   msr_merge #(
      .MAX_VERTICES (MAX_VERTICES),
      .SW           (SW)
   ) u_merge (
      .clock   (clock),
      .ctl     (mrg_ctl),
      .idx     (mrg_idx),
      .acc     (lane_acc[k_ff]),
      .rd_data (max_rd)
   );

   msr_isqrt #(
      .W (SW)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_QRD),
      .value (max_rd),
      .sts   (sq_sts),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 2'd0;
      end else begin
         // A new radius in the output state refills the register itself.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_QOUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff     <= req_data.mode;
                  raw_ff[0]   <= req_data.vertex_index;
                  raw_ff[1]   <= req_data.corner_a;
                  raw_ff[2]   <= req_data.corner_b;
                  raw_ff[3]   <= req_data.corner_c;
                  coord_ff[0] <= COORD_BITS'($unsigned(req_data.pos_x));
                  coord_ff[1] <= COORD_BITS'($unsigned(req_data.pos_y));
                  coord_ff[2] <= COORD_BITS'($unsigned(req_data.pos_z));
                  state_ff    <= ST_WRAP1;
               end
            end
            ST_WRAP1: begin
               q_ff     <= q_in;
               state_ff <= ST_WRAP2;
            end
            ST_WRAP2: begin
               idx_ff   <= idx_in;
               state_ff <= ST_DISPATCH;
            end
            ST_DISPATCH: begin
               k_ff <= 2'd0;
               unique case (mode_ff)
                  msr_pkg::MODE_FACE:  state_ff <= ST_F1;
                  msr_pkg::MODE_QUERY: state_ff <= ST_QRD;
                  default:             state_ff <= ST_IDLE;
               endcase
            end
            ST_F1:  state_ff <= ST_F2;
            ST_F2:  state_ff <= ST_MRD;
            ST_MRD: state_ff <= ST_MWR;
            ST_MWR: begin
               if (k_ff == 2'd2) begin
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_MRD;
               end
            end
            ST_QRD: state_ff <= ST_QSQ;
            ST_QSQ: begin
               if (sq_sts.done) begin
                  prod_ff  <= prod_in;
                  state_ff <= ST_QOUT;
               end
            end
            ST_QOUT: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.query_index <= FW'(idx_ff[0]);
                  rsp_data_ff.radius      <= msr_pkg::RADIUS_W'(prod_ff >> K5);
                  state_ff                <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MSR_ASSERT_IMPL(a_rsp_from_query, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_QOUT, "result raised outside query output")
   `MSR_ASSERT_IMPL(a_sqrt_done_in_wait, clock, reset, sq_sts.done, state_ff == ST_QSQ, "square root finished outside its wait state")
   `MSR_ASSERT_IMPL(a_merge_one_write, clock, reset, mrg_ctl.upd || mrg_ctl.clr, !(mrg_ctl.upd && mrg_ctl.clr) && (k_ff != 2'd3), "maximum store write conflict")
   `MSR_ASSERT_NEXT(a_result_held, clock, reset, (state_ff == ST_QOUT) && !out_free, state_ff == ST_QOUT, "pending radius lost")

endmodule

>>> src/msr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_lane
// One corner lane: its own copy of the position store and the scaled
// squared distance of its corner to the face centroid.
// ----------------------------------------------------------------------------
module msr_lane #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                                      clock,
   input  msr_pkg::lane_ctl_type                     ctl,
   input  logic [$clog2(MAX_VERTICES)-1:0]           wr_idx,
   input  logic [2:0][COORD_BITS-1:0]                wr_pos,
   input  logic [$clog2(MAX_VERTICES)-1:0]           rd_idx,
   input  logic [2:0][COORD_BITS+1:0]                sum_ax,
   output logic [2:0][COORD_BITS-1:0]                pos,
   output logic [2*COORD_BITS+3:0]                   acc
);

   localparam int DW = COORD_BITS + 3;
   localparam int MW = COORD_BITS + 2;
   localparam int SW = 2 * COORD_BITS + 4;

   logic [3*COORD_BITS-1:0]   mem_ff [MAX_VERTICES];
   logic [2:0][COORD_BITS-1:0] pos_ff;
   logic [SW-1:0]             sq_ff  [3];
   logic [SW-1:0]             sq_in  [3];
   logic [SW-1:0]             acc_ff;
   logic [SW-1:0]             acc_in;
   logic signed [DW-1:0]      p_ext  [3];
   logic signed [DW-1:0]      diff   [3];
   logic [MW-1:0]             mag    [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p_ext[j] = DW'($signed(pos_ff[j]));
         diff[j]  = p_ext[j] + (p_ext[j] <<< 1) - DW'($signed(sum_ax[j]));
         mag[j]   = diff[j][DW-1] ? MW'(-diff[j]) : MW'(diff[j]);
         sq_in[j] = SW'(mag[j]) * SW'(mag[j]);
      end
      acc_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_idx] <= wr_pos;
      end
      if (ctl.rd_en) begin
         pos_ff <= mem_ff[rd_idx];
      end
      for (int j = 0; j < 3; j++) begin
         sq_ff[j] <= sq_in[j];
      end
      acc_ff <= acc_in;
   end

   assign pos = pos_ff;
   assign acc = acc_ff;

endmodule

>>> src/msr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_merge
// Running maximum store: folds each lane's result into its vertex entry.
// ----------------------------------------------------------------------------
module msr_merge #(
   parameter int MAX_VERTICES = 1024,
   parameter int SW           = 36
) (
   input  logic                            clock,
   input  msr_pkg::merge_ctl_type          ctl,
   input  logic [$clog2(MAX_VERTICES)-1:0] idx,
   input  logic [SW-1:0]                   acc,
   output logic [SW-1:0]                   rd_data
);

   logic [SW-1:0] mem_ff [MAX_VERTICES];
   logic [SW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      priority if (ctl.clr) begin
         mem_ff[idx] <= '0;
      end else if (ctl.upd && (acc > rd_data_ff)) begin
         mem_ff[idx] <= acc;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/msr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_isqrt
// Integer square root, one result bit per cycle, truncating.
// ----------------------------------------------------------------------------
module msr_isqrt #(
   parameter int W = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [W-1:0]         value,
   output msr_pkg::sqrt_sts_type sts,
   output logic [W/2-1:0]       root
);

   localparam int R  = W / 2;
   localparam int CW = $clog2(R + 1);

   logic [W-1:0]   val_ff;
   logic [R+1:0]   rem_ff;
   logic [R-1:0]   root_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [R+1:0]   rem_in;
   logic [R+1:0]   trial;
   logic           fits;

   always_comb begin
      rem_in = {rem_ff[R-1:0], val_ff[W-1:W-2]};
      trial  = {root_ff, 2'b01};
      fits   = (rem_in >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(R);
            val_ff  <= value;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            val_ff  <= val_ff << 2;
            rem_ff  <= fits ? (rem_in - trial) : rem_in;
            root_ff <= {root_ff[R-2:0], fits};
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mesh splat radius estimator.
// ----------------------------------------------------------------------------
// Loads mesh vertices, sends triangle faces over them and queries per-vertex
// radii. An internal shadow of both vertex stores predicts every radius, and
// each result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_VERTS   = 1024;
   localparam int RANDOM_BEATS = 1100;
   localparam int WATCHDOG    = 4000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   msr_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   msr_pkg::rsp_type rsp_data;

   mesh_splat_radius dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Shadow copies of the position store and the running maximum store.
   logic signed [15:0] shadow_pos [NUM_VERTS][3];
   logic [35:0]        shadow_max [NUM_VERTS];
   bit                 loaded     [NUM_VERTS];

   msr_pkg::rsp_type pending_radii [$];
   int      mismatch_count;
   int      checked_count;
   int      beats_sent;
   int      idle_cycles;
   bit      draining_done;
   bit      hold_off;      // request for a long receiver hold-off

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = n;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Advances the shadow state by one accepted beat and queues any radius.
   task automatic predict_radius(input msr_pkg::req_type beat);
      logic signed [63:0] sum [3];
      logic signed [63:0] diff;
      logic [63:0]        acc;
      logic [9:0]         corner [3];
      msr_pkg::rsp_type   exp_rsp;
      case (beat.mode)
         msr_pkg::MODE_LOAD: begin
            shadow_pos[beat.vertex_index][0] = beat.pos_x;
            shadow_pos[beat.vertex_index][1] = beat.pos_y;
            shadow_pos[beat.vertex_index][2] = beat.pos_z;
            shadow_max[beat.vertex_index]    = '0;
            loaded[beat.vertex_index]        = 1'b1;
         end
         msr_pkg::MODE_FACE: begin
            corner[0] = beat.corner_a;
            corner[1] = beat.corner_b;
            corner[2] = beat.corner_c;
            for (int j = 0; j < 3; j++)
               sum[j] = 64'(shadow_pos[corner[0]][j]) + 64'(shadow_pos[corner[1]][j])
                      + 64'(shadow_pos[corner[2]][j]);
            // Corners update in order a, b, c; a repeated corner keeps the larger.
            for (int k = 0; k < 3; k++) begin
               acc = 0;
               for (int j = 0; j < 3; j++) begin
                  diff = 3 * 64'(shadow_pos[corner[k]][j]) - sum[j];
                  if (diff < 0) diff = -diff;
                  acc += diff * diff;
               end
               if (acc > 64'(shadow_max[corner[k]])) shadow_max[corner[k]] = acc[35:0];
            end
         end
         msr_pkg::MODE_QUERY: begin
            exp_rsp.query_index = beat.vertex_index;
            exp_rsp.radius      = 17'((2 * root_floor(64'(shadow_max[beat.vertex_index]))) / 5);
            pending_radii.push_back(exp_rsp);
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sender. Beats are handed over through a queue so the directed table,
   // the random part and the pauses are written as plain sequential code.
   // ---------------------------------------------------------------------
   msr_pkg::rsp_type typed_radii [$];   // directed rows with a hand-written answer

   task automatic send_beat(input msr_pkg::req_type beat);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!(req_valid && !req_stall));
      beats_sent++;
      predict_radius(beat);
      req_valid <= 1'b0;
   endtask

   function automatic msr_pkg::req_type make_load(input logic [9:0] idx,
                                                  input logic [15:0] x, y, z);
      msr_pkg::req_type b;
      b.mode = msr_pkg::MODE_LOAD; b.vertex_index = idx;
      b.pos_x = x; b.pos_y = y; b.pos_z = z;
      b.corner_a = 10'($urandom()); b.corner_b = 10'($urandom());
      b.corner_c = 10'($urandom());
      return b;
   endfunction

   function automatic msr_pkg::req_type make_face(input logic [9:0] a, b, c);
      msr_pkg::req_type r;
      r.mode = msr_pkg::MODE_FACE; r.vertex_index = 10'($urandom());
      r.pos_x = 16'($urandom()); r.pos_y = 16'($urandom()); r.pos_z = 16'($urandom());
      r.corner_a = a; r.corner_b = b; r.corner_c = c;
      return r;
   endfunction

   function automatic msr_pkg::req_type make_query(input logic [9:0] idx);
      msr_pkg::req_type r;
      r = make_face(10'($urandom()), 10'($urandom()), 10'($urandom()));
      r.mode = msr_pkg::MODE_QUERY; r.vertex_index = idx;
      return r;
   endfunction

   function automatic logic [9:0] pick_loaded();
      logic [9:0] idx;
      do idx = 10'($urandom()); while (!loaded[idx]);
      return idx;
   endfunction

   // Waits until every radius has come back, plus a settling margin for
   // the face pipeline, which produces no result of its own.
   task automatic wait_drained();
      while (pending_radii.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Directed table: the expected radius is typed in where it is obvious.
   typedef struct {
      msr_pkg::req_type beat;
      bit               has_typed;
      logic [16:0]      typed_radius;
   } table_row;

   table_row directed [$];

   task automatic build_table();
      table_row row;
      row.has_typed = 0; row.typed_radius = 0;
      // Extremes of the coordinates at the ends of the index range.
      row.beat = make_load(10'd0, 16'sh8000, 16'sh8000, 16'sh8000);   directed.push_back(row);
      row.beat = make_load(10'd1023, 16'sh7fff, 16'sh7fff, 16'sh7fff); directed.push_back(row);
      row.beat = make_load(10'd512, 16'sh0000, 16'sh0000, 16'sh0000);  directed.push_back(row);
      // A freshly loaded vertex has a zero maximum.
      row.beat = make_query(10'd0); row.has_typed = 1; row.typed_radius = 0;
      directed.push_back(row);
      row.has_typed = 0;
      // Largest spread face; its radius is checked by prediction.
      row.beat = make_face(10'd0, 10'd1023, 10'd512); directed.push_back(row);
      row.beat = make_query(10'd0);    directed.push_back(row);
      row.beat = make_query(10'd1023); directed.push_back(row);
      row.beat = make_query(10'd512);  directed.push_back(row);
      // Degenerate face with all corners equal gives zero distance.
      row.beat = make_load(10'd7, 16'sh1234, 16'shedcb, 16'sh0100); directed.push_back(row);
      row.beat = make_face(10'd7, 10'd7, 10'd7); directed.push_back(row);
      row.beat = make_query(10'd7); row.has_typed = 1; row.typed_radius = 0;
      directed.push_back(row);
      row.has_typed = 0;
      // Repeated corner pair, then an unused mode that must change nothing.
      row.beat = make_face(10'd7, 10'd0, 10'd0); directed.push_back(row);
      row.beat = make_query(10'd7); directed.push_back(row);
      row.beat = make_query(10'd0); row.beat.mode = MODE_UNUSED; directed.push_back(row);
      row.beat = make_query(10'd0); directed.push_back(row);
      // Reloading clears the maximum.
      row.beat = make_load(10'd1023, 16'sh7fff, 16'sh8000, 16'sh0001); directed.push_back(row);
      row.beat = make_query(10'd1023); row.has_typed = 1; row.typed_radius = 0;
      directed.push_back(row);
   endtask

   initial begin
      msr_pkg::req_type beat;
      int      roll;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      hold_off  = 1'b0;
      mismatch_count = 0;
      checked_count  = 0;
      beats_sent     = 0;
      draining_done  = 1'b0;
      for (int i = 0; i < NUM_VERTS; i++) loaded[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      build_table();
      foreach (directed[i]) begin
         if (directed[i].has_typed) begin
            typed_radii.push_back('{query_index: directed[i].beat.vertex_index,
                                    radius: directed[i].typed_radius});
         end
         send_beat(directed[i].beat);
      end
      // The sender pauses until everything directed has come back.
      wait_drained();

      // Random part: loads (all of the first 40 beats, some of a small working set),
      // faces over and queries of loaded vertices; a little unused-mode noise.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 400) hold_off = 1'b1;  // a long receiver hold-off begins
         roll = $urandom_range(0, 99);
         if (n < 40 || roll < 15) begin
            case ($urandom_range(0, 3))
               0: beat = make_load(10'($urandom()), 16'sh8000, 16'sh7fff, 16'($urandom()));
               1: beat = make_load(10'($urandom_range(0, 63)), 16'($urandom()),
                                   16'($urandom()), 16'($urandom()));
               default: beat = make_load(10'($urandom()), 16'($urandom()),
                                         16'($urandom()), 16'($urandom()));
            endcase
         end else if (roll < 60) begin
            beat = make_face(pick_loaded(), pick_loaded(), pick_loaded());
         end else if (roll < 97) begin
            beat = make_query(pick_loaded());
         end else begin
            beat = make_query(10'($urandom())); beat.mode = MODE_UNUSED;
         end
         send_beat(beat);
         if (n == 800) wait_drained();
      end

      wait_drained();
      draining_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off, and the comparison.
   // ---------------------------------------------------------------------
   initial begin
      int stall_len;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         // Accept this beat; the next iteration decides the next stall.
         check_radius(rsp_data);
      end
   end

   task automatic check_radius(input msr_pkg::rsp_type got);
      msr_pkg::rsp_type want;
      if (pending_radii.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected radius beat: index %0d radius %0d",
                     got.query_index, got.radius);
         return;
      end
      want = pending_radii.pop_front();
      checked_count++;
      if (typed_radii.size() != 0 && typed_radii[0].query_index == got.query_index
          && want.query_index == typed_radii[0].query_index) begin
         // Hand-typed answers must agree with the prediction as well.
         if (typed_radii[0].radius != want.radius) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("typed radius disagrees: index %0d typed %0d predicted %0d",
                        want.query_index, typed_radii[0].radius, want.radius);
         end
         void'(typed_radii.pop_front());
      end
      if (got.query_index !== want.query_index || got.radius !== want.radius) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("radius mismatch: expected index %0d radius %0d, got index %0d radius %0d",
                     want.query_index, want.radius, got.query_index, got.radius);
      end
   endtask

   // Watchdog: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      while (!draining_done && idle_cycles < WATCHDOG) @(posedge clock);
      if (!draining_done) begin
         $display("timeout with %0d radii outstanding", pending_radii.size());
         $display("mesh_splat_radius: mismatch");
         $finish;
      end else begin
         $display("Covered %0d beats of loads, faces, queries and unused-mode noise;",
                  beats_sent);
         $display("%0d radii compared, %0d failures.", checked_count, mismatch_count);
         if (mismatch_count == 0 && pending_radii.size() == 0)
            $display("mesh_splat_radius: match");
         else
            $display("mesh_splat_radius: mismatch");
         $finish;
      end
   end

endmodule

>>> filelist.f
+incdir+src
src/msr_pkg.sv
src/msr_lane.sv
src/msr_merge.sv
src/msr_isqrt.sv
src/mesh_splat_radius.sv
verif/testbench.sv
